FILE: rtl/core/rfpa_pkg.sv
// ----------------------------------------------------------------------------
// rfpa_pkg
// Shared types, operation codes and helpers for the RGBA fade/pulse animator.
// ----------------------------------------------------------------------------
package rfpa_pkg;

	localparam int NumCh     = 4;
	localparam int DivSteps  = 33;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_FADE     = 3'd1;
	localparam logic [2:0] OP_FADE_RGB = 3'd2;
	localparam logic [2:0] OP_SET      = 3'd3;
	localparam logic [2:0] OP_PULSE    = 3'd4;

	localparam logic [2:0] REG_COLOR_A  = 3'd0;
	localparam logic [2:0] REG_COLOR_B  = 3'd1;
	localparam logic [2:0] REG_DURATION = 3'd2;
	localparam logic [2:0] REG_DELAY    = 3'd3;
	localparam logic [2:0] REG_EPSILON  = 3'd4;

	localparam logic [1:0] PH_TO_B   = 2'd0;
	localparam logic [1:0] PH_TO_A   = 2'd1;
	localparam logic [1:0] PH_DELAY  = 2'd2;

	localparam logic [31:0] FULL_LEVEL = 32'hFFFF_0000;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_TICK_MUL,
		CMD_TICK_ADD,
		CMD_PULSE,
		CMD_SRC_INPUT,
		CMD_SET_INPUT,
		CMD_SET_A,
		CMD_SET_SRC,
		CMD_DIFF,
		CMD_CHECK,
		CMD_DIV_START,
		CMD_DIV_WRITE,
		CMD_OUTPUT
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t   code;
		logic [1:0]  ch;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        fade_active;
		logic        pulse_active;
		logic [1:0]  phase;
		logic        dur_zero;
		logic        near;
		logic        same_run;
		logic        count4;
		logic        div_done;
	} dp_status_t;

	// floor(x / 257): x >> 8 overshoots by at most one
	function automatic logic [7:0] level_to_byte(input logic [15:0] x);
		logic [7:0]  q0;
		logic [15:0] p;
		begin
			q0 = x[15:8];
			p  = {q0, 8'h00} + {8'h00, q0};
			level_to_byte = (p <= x) ? q0 : q0 - 8'd1;
		end
	endfunction

endpackage

FILE: rtl/core/rfpa_div.sv
// ----------------------------------------------------------------------------
// rfpa_div
// Restoring divider, 33-bit dividend by 16-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rfpa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [32:0] quotient
);
	import rfpa_pkg::*;

	logic [32:0] num_q;
	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_next;
	logic        fits;

	assign rem_next = {rem_q, num_q[32]};
	assign fits     = rem_next >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], fits};
			rem_q <= fits ? 16'(rem_next - {1'b0, den_q}) : rem_next[15:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

FILE: rtl/core/rfpa_datapath.sv
// ----------------------------------------------------------------------------
// rfpa_datapath
// Channel levels, slopes, targets, pulse state and config; executes commands.
// ----------------------------------------------------------------------------
module rfpa_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rfpa_pkg::dp_cmd_t    cmd,
	output rfpa_pkg::dp_status_t status,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic [2:0]           operation,
	input  logic [15:0]          target_red,
	input  logic [15:0]          target_green,
	input  logic [15:0]          target_blue,
	input  logic [15:0]          target_alpha,
	input  logic [15:0]          fade_ms,
	input  logic [15:0]          elapsed_ms,
	output logic [7:0]           red_byte,
	output logic [7:0]           green_byte,
	output logic [7:0]           blue_byte,
	output logic [7:0]           alpha_byte,
	output logic                 fading,
	output logic                 pulsing,
	output logic [1:0]           pulse_phase
);
	import rfpa_pkg::*;

	// config
	logic [63:0] color_a_q, color_b_q;
	logic [15:0] duration_q, delay_cfg_q, epsilon_q;

	// animator state
	logic [31:0]        level_q [NumCh];
	logic signed [32:0] slope_q [NumCh];
	logic [15:0]        tgt_q   [NumCh];
	logic               fade_active_q, pulse_active_q;
	logic [15:0]        fade_len_q, delay_left_q;
	logic [1:0]         phase_q;
	logic               near_q, same_q, all_hit_q;

	// per-item working registers
	logic [2:0]         op_q;
	logic [15:0]        in_tgt_q  [NumCh];
	logic [15:0]        ms_q, in_dur_q;
	logic [15:0]        src_tgt_q [NumCh];
	logic [15:0]        src_dur_q;
	logic               count4_q;
	logic signed [32:0] d_q [NumCh];
	logic signed [49:0] prod_s1;

	logic [7:0] red_q, green_q, blue_q, alpha_q;
	logic       fading_q, pulsing_q;
	logic [1:0] phase_out_q;

	logic [1:0]  ch;
	logic [15:0] color_a [NumCh];
	logic [15:0] color_b [NumCh];

	assign ch = cmd.ch;

	always_comb begin
		for (int i = 0; i < NumCh; i++) begin
			color_a[i] = color_a_q[63 - 16*i -: 16];
			color_b[i] = color_b_q[63 - 16*i -: 16];
		end
	end

	// difference toward the source target
	logic signed [32:0] d_c;
	logic [32:0]        absd_c, eps_ext, absd_q_c, dividend;
	logic               near_c, same_c, same_run;

	assign d_c      = $signed({1'b0, src_tgt_q[ch], 16'h0000}) - $signed({1'b0, level_q[ch]});
	assign absd_c   = d_c[32] ? 33'(-d_c) : 33'(d_c);
	assign eps_ext  = {1'b0, epsilon_q, 16'h0000};
	assign near_c   = (ch == 2'd3) ? (absd_c <= eps_ext) : (absd_c < eps_ext);
	assign same_c   = src_tgt_q[ch] == tgt_q[ch];
	assign same_run = fade_active_q && same_q && (fade_len_q == src_dur_q);
	assign absd_q_c = d_q[ch][32] ? 33'(-d_q[ch]) : 33'(d_q[ch]);
	assign dividend = absd_q_c + {17'h0, src_dur_q} - 33'd1;

	// tick update of one channel
	logic signed [50:0] v_c, t_c, vs_c;
	logic               hit_c;
	logic [31:0]        new_level;

	always_comb begin
		v_c   = $signed({19'h0, level_q[ch]}) + 51'(prod_s1);
		t_c   = $signed({19'h0, tgt_q[ch], 16'h0000});
		hit_c = slope_q[ch][32] ? (v_c <= t_c) : (v_c >= t_c);
		vs_c  = hit_c ? t_c : v_c;
		if (vs_c < 0)
			new_level = '0;
		else if (vs_c > $signed({19'h0, FULL_LEVEL}))
			new_level = FULL_LEVEL;
		else
			new_level = vs_c[31:0];
	end

	logic        div_done;
	logic [32:0] quot;

	rfpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.code == CMD_DIV_START),
		.dividend (dividend),
		.divisor  (src_dur_q),
		.done     (div_done),
		.quotient (quot)
	);

	// control state and animator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_a_q      <= '0;
			color_b_q      <= '0;
			duration_q     <= '0;
			delay_cfg_q    <= '0;
			epsilon_q      <= 16'd1;
			for (int i = 0; i < NumCh; i++) begin
				level_q[i] <= '0;
				slope_q[i] <= '0;
				tgt_q[i]   <= '0;
			end
			fade_active_q  <= 1'b0;
			pulse_active_q <= 1'b0;
			fade_len_q     <= '0;
			delay_left_q   <= '0;
			phase_q        <= PH_TO_B;
			near_q         <= 1'b0;
			same_q         <= 1'b0;
			all_hit_q      <= 1'b0;
			count4_q       <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COLOR_A:  color_a_q   <= cfg_data;
					REG_COLOR_B:  color_b_q   <= cfg_data;
					REG_DURATION: duration_q  <= cfg_data[15:0];
					REG_DELAY:    delay_cfg_q <= cfg_data[15:0];
					REG_EPSILON:  epsilon_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (cmd.code)
				CMD_TICK_ADD: begin
					level_q[ch] <= new_level;
					all_hit_q   <= (ch == 2'd0) ? hit_c : (all_hit_q & hit_c);
					if (ch == 2'd3 && all_hit_q && hit_c)
						fade_active_q <= 1'b0;
				end
				CMD_PULSE: begin
					case (phase_q)
						PH_TO_B: begin
							count4_q <= 1'b1;
							phase_q  <= PH_TO_A;
						end
						PH_TO_A: begin
							count4_q     <= 1'b1;
							phase_q      <= PH_DELAY;
							delay_left_q <= delay_cfg_q;
						end
						default: begin
							if (ms_q >= delay_left_q) begin
								delay_left_q <= '0;
								phase_q      <= PH_TO_B;
							end else begin
								delay_left_q <= delay_left_q - ms_q;
							end
						end
					endcase
				end
				CMD_SRC_INPUT: count4_q <= (op_q == OP_FADE);
				CMD_SET_INPUT: begin
					for (int i = 0; i < NumCh; i++)
						level_q[i] <= {in_tgt_q[i], 16'h0000};
					fade_active_q <= 1'b0;
				end
				CMD_SET_A: begin
					for (int i = 0; i < NumCh; i++)
						level_q[i] <= {color_a[i], 16'h0000};
					fade_active_q <= 1'b0;
					if (duration_q != 16'd0) begin
						phase_q        <= PH_TO_B;
						delay_left_q   <= '0;
						pulse_active_q <= 1'b1;
					end
				end
				CMD_SET_SRC: begin
					for (int i = 0; i < NumCh; i++)
						if (i < 3 || count4_q)
							level_q[i] <= {src_tgt_q[i], 16'h0000};
					fade_active_q <= 1'b0;
				end
				CMD_DIFF: begin
					near_q <= (ch == 2'd0) ? near_c : (near_q & near_c);
					same_q <= (ch == 2'd0) ? same_c : (same_q & same_c);
				end
				CMD_CHECK: begin
					if (near_q) begin
						fade_active_q <= 1'b0;
					end else if (!same_run) begin
						fade_active_q <= 1'b1;
						fade_len_q    <= src_dur_q;
						if (!count4_q) begin
							tgt_q[3]   <= level_q[3][31:16];
							slope_q[3] <= '0;
						end
					end
				end
				CMD_DIV_WRITE: begin
					tgt_q[ch]   <= src_tgt_q[ch];
					slope_q[ch] <= d_q[ch][32] ? $signed(33'(-quot)) : $signed(quot);
				end
				default: ;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_CAPTURE: begin
				op_q        <= operation;
				in_tgt_q[0] <= target_red;
				in_tgt_q[1] <= target_green;
				in_tgt_q[2] <= target_blue;
				in_tgt_q[3] <= target_alpha;
				in_dur_q    <= fade_ms;
				ms_q        <= elapsed_ms;
			end
			CMD_TICK_MUL: prod_s1 <= slope_q[ch] * $signed({1'b0, ms_q});
			CMD_PULSE: begin
				src_dur_q <= {1'b0, duration_q[15:1]};
				for (int i = 0; i < NumCh; i++)
					src_tgt_q[i] <= (phase_q == PH_TO_B) ? color_b[i] : color_a[i];
			end
			CMD_SRC_INPUT: begin
				src_dur_q <= in_dur_q;
				for (int i = 0; i < NumCh; i++)
					src_tgt_q[i] <= in_tgt_q[i];
			end
			CMD_DIFF: d_q[ch] <= d_c;
			CMD_OUTPUT: begin
				red_q       <= level_to_byte(level_q[0][31:16]);
				green_q     <= level_to_byte(level_q[1][31:16]);
				blue_q      <= level_to_byte(level_q[2][31:16]);
				alpha_q     <= level_to_byte(level_q[3][31:16]);
				fading_q    <= fade_active_q;
				pulsing_q   <= pulse_active_q;
				phase_out_q <= phase_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		status.op           = op_q;
		status.fade_active  = fade_active_q;
		status.pulse_active = pulse_active_q;
		status.phase        = phase_q;
		status.dur_zero     = src_dur_q == 16'd0;
		status.near         = near_q;
		status.same_run     = same_run;
		status.count4       = count4_q;
		status.div_done     = div_done;
	end

	assign red_byte    = red_q;
	assign green_byte  = green_q;
	assign blue_byte   = blue_q;
	assign alpha_byte  = alpha_q;
	assign fading      = fading_q;
	assign pulsing     = pulsing_q;
	assign pulse_phase = phase_out_q;

endmodule

FILE: rtl/core/rfpa_ctrl.sv
// ----------------------------------------------------------------------------
// rfpa_ctrl
// Sequencer: walks the channels for tick, fade setup and slope division.
// ----------------------------------------------------------------------------
module rfpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  rfpa_pkg::dp_status_t status,
	output rfpa_pkg::dp_cmd_t    cmd
);
	import rfpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_TICK_MUL,
		S_TICK_ADD,
		S_PULSE,
		S_FADE_START,
		S_DIFF,
		S_CHECK,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] ch_q;
	logic       out_valid_q;
	logic [1:0] last_ch;
	logic       out_free;
	logic       pulse_go;

	assign last_ch  = status.count4 ? 2'd3 : 2'd2;
	assign out_free = !out_valid_q || out_ready;
	assign pulse_go = status.pulse_active && !status.fade_active;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd.ch   = ch_q;
		cmd.code = CMD_NONE;
		case (state_q)
			S_IDLE:     if (in_valid) cmd.code = CMD_CAPTURE;
			S_DISPATCH: begin
				case (status.op)
					OP_FADE, OP_FADE_RGB: cmd.code = CMD_SRC_INPUT;
					OP_SET:               cmd.code = CMD_SET_INPUT;
					OP_PULSE:             cmd.code = CMD_SET_A;
					default:              cmd.code = CMD_NONE;
				endcase
			end
			S_TICK_MUL:   cmd.code = CMD_TICK_MUL;
			S_TICK_ADD:   cmd.code = CMD_TICK_ADD;
			S_PULSE:      if (pulse_go) cmd.code = CMD_PULSE;
			S_FADE_START: if (status.dur_zero) cmd.code = CMD_SET_SRC;
			S_DIFF:       cmd.code = CMD_DIFF;
			S_CHECK:      cmd.code = CMD_CHECK;
			S_DIV_GO:     cmd.code = CMD_DIV_START;
			S_DIV_WAIT:   if (status.div_done) cmd.code = CMD_DIV_WRITE;
			S_DONE:       if (out_free) cmd.code = CMD_OUTPUT;
			default:      cmd.code = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// held beat stays until taken; a new one loads when the register is free
			out_valid_q <= (out_valid_q && !out_ready) || (state_q == S_DONE && out_free);
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					ch_q <= '0;
					case (status.op)
						OP_TICK:              state_q <= status.fade_active ? S_TICK_MUL : S_PULSE;
						OP_FADE, OP_FADE_RGB: state_q <= S_FADE_START;
						default:              state_q <= S_DONE;
					endcase
				end
				S_TICK_MUL: state_q <= S_TICK_ADD;
				S_TICK_ADD: begin
					if (ch_q == 2'd3) begin
						state_q <= S_PULSE;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_TICK_MUL;
					end
				end
				S_PULSE: begin
					ch_q <= '0;
					if (pulse_go && (status.phase == PH_TO_B || status.phase == PH_TO_A))
						state_q <= S_FADE_START;
					else
						state_q <= S_DONE;
				end
				S_FADE_START: begin
					ch_q    <= '0;
					state_q <= status.dur_zero ? S_DONE : S_DIFF;
				end
				S_DIFF: begin
					if (ch_q == last_ch) begin
						state_q <= S_CHECK;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				S_CHECK: begin
					ch_q    <= '0;
					state_q <= (status.near || status.same_run) ? S_DONE : S_DIV_GO;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (status.div_done) begin
						if (ch_q == last_ch) begin
							state_q <= S_DONE;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/rgba_fade_pulse_animator_unit.sv
// ----------------------------------------------------------------------------
// rgba_fade_pulse_animator_unit
// Four-channel color level with linear fades and a repeating A-B-A pulse.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: a tick with the
//   elapsed milliseconds, a fade, a direct color set or a pulse start. Every
//   input beat yields exactly one output beat (out_valid/out_ready) with the
//   four channels as bytes and the fade/pulse flags after the command.
//   Config channel (cfg_valid/cfg_ready) is always ready; write only while
//   the unit is idle. Indexes: 0 color A, 1 color B, 2 pulse period,
//   3 repeat delay, 4 epsilon.
//   A tick with a fade updates each channel in turn (multiply, then add). A
//   fade that sets new slopes runs a shared bit-serial divider once per
//   channel, and a tick that ends a fade can start the next pulse leg. One
//   command is processed at a time.
//   After reset all levels are zero, no fade or pulse runs, epsilon is 1.
//   If the receiver stalls, the finished beat is held in the output register
//   and the next command is already accepted and processed; its result waits
//   until the held beat is taken.
// ----------------------------------------------------------------------------
module rgba_fade_pulse_animator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [15:0] target_red,
	input  logic [15:0] target_green,
	input  logic [15:0] target_blue,
	input  logic [15:0] target_alpha,
	input  logic [15:0] fade_ms,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_byte,
	output logic [7:0]  green_byte,
	output logic [7:0]  blue_byte,
	output logic [7:0]  alpha_byte,
	output logic        fading,
	output logic        pulsing,
	output logic [1:0]  pulse_phase,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import rfpa_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rfpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rfpa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.target_red   (target_red),
		.target_green (target_green),
		.target_blue  (target_blue),
		.target_alpha (target_alpha),
		.fade_ms      (fade_ms),
		.elapsed_ms   (elapsed_ms),
		.red_byte     (red_byte),
		.green_byte   (green_byte),
		.blue_byte    (blue_byte),
		.alpha_byte   (alpha_byte),
		.fading       (fading),
		.pulsing      (pulsing),
		.pulse_phase  (pulse_phase)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGBA fade/pulse animator. Every command beat is
// fed to a fade/pulse predictor. Each output beat is compared, field by field,
// with the oldest predicted color. The run covers directed corner commands
// and then random tick/fade/set/pulse traffic under three register settings,
// with random idling on both channels except under the last setting.
// ----------------------------------------------------------------------------
module tb_top;
	import rfpa_pkg::*;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic [15:0] fade_len;
		logic [15:0] elapsed;
	} anim_cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       fading;
		logic       pulsing;
		logic [1:0] phase;
	} color_out_t;

	typedef logic [15:0] chan4_t [4];

	class fade_scoreboard;
		logic [63:0] color_a, color_b;
		logic [15:0] duration, rep_delay, eps;
		logic [31:0] level [4];
		longint      slope [4];
		logic [15:0] target [4];
		bit          fade_on, pulse_on;
		logic [15:0] fade_len;
		logic [1:0]  ph;
		int          delay_left;
		color_out_t  expected_colors [$];
		int          errors, checked;

		function new();
			color_a = '0; color_b = '0; duration = '0; rep_delay = '0; eps = 16'd1;
			foreach (level[i]) begin
				level[i] = '0; slope[i] = 0; target[i] = '0;
			end
			fade_on = 0; pulse_on = 0; fade_len = '0; ph = PH_TO_B; delay_left = 0;
			errors = 0; checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] d);
			case (idx)
				REG_COLOR_A:  color_a = d;
				REG_COLOR_B:  color_b = d;
				REG_DURATION: duration = d[15:0];
				REG_DELAY:    rep_delay = d[15:0];
				REG_EPSILON:  eps = d[15:0];
				default: ;
			endcase
		endfunction

		function void set_color(chan4_t t, int count);
			for (int i = 0; i < count; i++) level[i] = {t[i], 16'h0000};
			fade_on = 0;
		endfunction

		function void start_fade(chan4_t t, logic [15:0] dur, int count);
			longint d [4];
			longint e, a, mag;
			bit near, same;
			e = longint'(eps) << 16;
			near = 1;
			same = 1;
			if (dur == 0) begin
				set_color(t, count);
				return;
			end
			for (int i = 0; i < count; i++) begin
				d[i] = (longint'(t[i]) << 16) - longint'(level[i]);
				a = d[i] < 0 ? -d[i] : d[i];
				// alpha of a full fade counts as near when exactly at epsilon
				if (i < 3) begin
					if (!(a < e)) near = 0;
				end else if (!(a <= e)) near = 0;
				if (t[i] != target[i]) same = 0;
			end
			if (near) begin
				fade_on = 0;
				return;
			end
			if (fade_on && same && fade_len == dur) return;
			fade_on = 1;
			fade_len = dur;
			for (int i = 0; i < count; i++) begin
				a = d[i] < 0 ? -d[i] : d[i];
				mag = (a + longint'(dur) - 1) / longint'(dur);
				target[i] = t[i];
				slope[i] = d[i] < 0 ? -mag : mag;
			end
			if (count == 3) begin
				target[3] = level[3][31:16];
				slope[3] = 0;
			end
		endfunction

		function chan4_t unpack(logic [63:0] c);
			chan4_t t;
			t[0] = c[63:48]; t[1] = c[47:32]; t[2] = c[31:16]; t[3] = c[15:0];
			return t;
		endfunction

		function void tick(logic [15:0] ms);
			longint tt, v;
			int matched;
			matched = 0;
			if (fade_on) begin
				for (int i = 0; i < 4; i++) begin
					tt = longint'(target[i]) << 16;
					v = longint'(level[i]) + slope[i] * longint'(ms);
					if (slope[i] < 0) begin
						if (v <= tt) begin v = tt; matched++; end
					end else if (v >= tt) begin
						v = tt; matched++;
					end
					if (v < 0) v = 0;
					if (v > longint'(FULL_LEVEL)) v = longint'(FULL_LEVEL);
					level[i] = v[31:0];
				end
				if (matched >= 4) fade_on = 0;
			end
			if (pulse_on && !fade_on) begin
				if (ph == PH_TO_B) begin
					start_fade(unpack(color_b), duration / 2, 4);
					ph = PH_TO_A;
				end else if (ph == PH_TO_A) begin
					start_fade(unpack(color_a), duration / 2, 4);
					ph = PH_DELAY;
					delay_left = rep_delay;
				end else if (int'(ms) >= delay_left) begin
					delay_left = 0;
					ph = PH_TO_B;
				end else delay_left -= ms;
			end
		endfunction

		function logic [7:0] to_byte(logic [31:0] l);
			logic [63:0] p;
			p = (64'(l) * 64'd255) / 64'hFFFF_0000;
			return p[7:0];
		endfunction

		function void note_command(anim_cmd_t c);
			chan4_t t;
			color_out_t r;
			t[0] = c.red; t[1] = c.green; t[2] = c.blue; t[3] = c.alpha;
			case (c.op)
				OP_TICK:     tick(c.elapsed);
				OP_FADE:     start_fade(t, c.fade_len, 4);
				OP_FADE_RGB: start_fade(t, c.fade_len, 3);
				OP_SET:      set_color(t, 4);
				OP_PULSE: begin
					set_color(unpack(color_a), 4);
					if (duration != 0) begin
						ph = PH_TO_B; delay_left = 0; pulse_on = 1;
					end
				end
				default: ;
			endcase
			r.red = to_byte(level[0]); r.green = to_byte(level[1]);
			r.blue = to_byte(level[2]); r.alpha = to_byte(level[3]);
			r.fading = fade_on; r.pulsing = pulse_on; r.phase = ph;
			expected_colors.push_back(r);
		endfunction

		function void check_color(color_out_t got);
			color_out_t e;
			checked++;
			if (expected_colors.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output beat %h", got);
				return;
			end
			e = expected_colors.pop_front();
			if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
					got.alpha !== e.alpha || got.fading !== e.fading ||
					got.pulsing !== e.pulsing || got.phase !== e.phase) begin
				errors++;
				if (errors <= 10)
					$display("beat %0d: exp rgba %h %h %h %h f%b p%b ph%0d, %s",
						checked, e.red, e.green, e.blue, e.alpha, e.fading, e.pulsing,
						e.phase, $sformatf("got %h %h %h %h f%b p%b ph%0d",
						got.red, got.green, got.blue, got.alpha, got.fading,
						got.pulsing, got.phase));
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 200;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0, in_ready;
	logic [2:0]  operation = '0;
	logic [15:0] target_red = '0, target_green = '0, target_blue = '0, target_alpha = '0;
	logic [15:0] fade_ms = '0, elapsed_ms = '0;
	logic        out_valid, out_ready = 0;
	logic [7:0]  red_byte, green_byte, blue_byte, alpha_byte;
	logic        fading, pulsing;
	logic [1:0]  pulse_phase;
	logic        cfg_valid = 0, cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	fade_scoreboard sb = new();
	int in_idle_pct, out_idle_pct;
	int quiet_cycles = 0;
	int n_ticks = 0, n_fades = 0, n_pulses = 0;
	anim_cmd_t last_fade = '0;

	rgba_fade_pulse_animator_unit u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_color({red_byte, green_byte, blue_byte, alpha_byte, fading, pulsing,
				pulse_phase});
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send(anim_cmd_t c);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1;
		{operation, target_red, target_green, target_blue, target_alpha, fade_ms,
			elapsed_ms} <= c;
		do @(posedge clk); while (!in_ready);
		sb.note_command(c);
		case (c.op)
			OP_TICK: n_ticks++;
			OP_FADE, OP_FADE_RGB: begin n_fades++; last_fade = c; end
			OP_PULSE: n_pulses++;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_colors.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		cfg_valid <= 0;
	endtask

	task automatic load_regs(logic [63:0] a, logic [63:0] b, logic [15:0] dur,
			logic [15:0] dly, logic [15:0] e);
		write_reg(REG_COLOR_A, a);
		write_reg(REG_COLOR_B, b);
		write_reg(REG_DURATION, dur);
		write_reg(REG_DELAY, dly);
		write_reg(REG_EPSILON, e);
	endtask

	function automatic anim_cmd_t cmd(logic [2:0] op, logic [15:0] r, logic [15:0] g,
			logic [15:0] b, logic [15:0] a, logic [15:0] fl, logic [15:0] el);
		return {op, r, g, b, a, fl, el};
	endfunction

	function automatic logic [15:0] pick_target(int ch);
		int sel;
		logic [15:0] cur;
		sel = $urandom_range(99);
		cur = sb.level[ch][31:16];
		if (sel < 10) return 16'h0000;
		if (sel < 20) return 16'hFFFF;
		if (sel < 40) return cur + 16'($urandom_range(0, 6)) - 16'd3;  // near current
		return 16'($urandom);
	endfunction

	function automatic anim_cmd_t rand_cmd();
		anim_cmd_t c;
		int sel;
		c = {3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom)};
		sel = $urandom_range(99);
		if (sel < 55) begin
			c.op = OP_TICK;
			if ($urandom_range(9) != 0) c.elapsed = 16'($urandom_range(0, 30));
		end else if (sel < 80) begin
			c.op = ($urandom_range(1)) ? OP_FADE : OP_FADE_RGB;
			c.red = pick_target(0); c.green = pick_target(1);
			c.blue = pick_target(2); c.alpha = pick_target(3);
			if ($urandom_range(9) != 0) c.fade_len = 16'($urandom_range(0, 120));
			if (last_fade.op != OP_TICK && $urandom_range(4) == 0) c = last_fade;
		end else if (sel < 88) c.op = OP_SET;
		else if (sel < 96) c.op = OP_PULSE;
		else if (sel < 98) c.op = 3'(OP_PULSE + 3'($urandom_range(1, 3)));
		return c;
	endfunction

	initial begin
		in_idle_pct = 25;
		out_idle_pct = 58;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// corners: zero-period pulse, extreme epsilon, alpha exactly at epsilon
		send(cmd(OP_PULSE, 0, 0, 0, 0, 0, 0));
		send(cmd(OP_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0));
		send(cmd(OP_FADE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 5, 0));
		send(cmd(OP_FADE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 5, 0));
		send(cmd(OP_FADE, 0, 16'h1234, 16'h8000, 0, 16'hFFFF, 0));
		send(cmd(OP_FADE, 0, 16'h1234, 16'h8000, 0, 16'hFFFF, 0));
		send(cmd(OP_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
		send(cmd(OP_FADE_RGB, 16'h00FF, 16'hFF00, 16'h5A5A, 0, 7, 0));
		send(cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
		send(cmd(OP_TICK, 0, 0, 0, 0, 0, 3));
		send(cmd(OP_FADE, 16'h0001, 16'hFFFE, 0, 16'h7FFF, 0, 0));
		send(cmd(3'(OP_PULSE + 1), 16'hFFFF, 0, 0, 0, 0, 0));
		send(cmd(3'(OP_PULSE + 3), 0, 0, 0, 0, 0, 0));
		drain();
		load_regs(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd65535, 16'd65535, 16'd65535);
		send(cmd(OP_FADE, 16'h8000, 0, 0, 0, 9, 0));
		send(cmd(OP_PULSE, 0, 0, 0, 0, 0, 0));
		send(cmd(OP_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
		send(cmd(OP_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
		send(cmd(OP_SET, 16'h4000, 0, 0, 0, 0, 0));
		drain();

		for (int phase_no = 0; phase_no < 3; phase_no++) begin
			case (phase_no)
				0: load_regs(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd40, 16'd10, 16'd1);
				1: begin
					load_regs({$urandom, $urandom}, {$urandom, $urandom}, 16'd3,
						16'd65535, 16'd0);
					in_idle_pct = 58; out_idle_pct = 25;
				end
				default: begin
					load_regs({$urandom, $urandom}, {$urandom, $urandom},
						16'($urandom_range(2, 300)), 16'($urandom_range(0, 40)),
						16'($urandom_range(0, 300)));
					in_idle_pct = 0; out_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 530; k++) begin
				send(rand_cmd());
				if (k == 260) begin
					in_valid <= 0;
					while (sb.expected_colors.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		$display("covered %0d beats: %0d ticks, %0d fades, %0d pulse starts",
			sb.checked, n_ticks, n_fades, n_pulses);
		$display("three register settings plus corners, with and without idling");
		if (sb.errors == 0 && sb.expected_colors.size() == 0)
			$display("end of test: clean");
		else begin
			$display("%0d mismatches, %0d beats missing", sb.errors, sb.expected_colors.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
